[src/level_trigger_pre_roll_gate_unit_macros.svh]
// Assertion helpers for the RTL file of the level trigger unit.
// Each helper checks an implication on the rising clock edge, with the
// check switched off while the synchronous active-low reset is asserted.
`ifndef LEVEL_TRIGGER_PRE_ROLL_GATE_UNIT_MACROS_SVH
`define LEVEL_TRIGGER_PRE_ROLL_GATE_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define LTPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define LTPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ltpg_pkg.sv]
// ----------------------------------------------------------------------------
// ltpg_pkg: shared types and constants of the level trigger unit
// Ring geometry, register indexes, sequencer states and the result bundle
// of the magnitude / level compare unit.
// ----------------------------------------------------------------------------
package ltpg_pkg;

  // Pre-roll ring geometry
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int RUN_W    = 16;
  localparam int PRE_W    = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_ROLL_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEADING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LEVEL  = 3'd5;

  // Register reset values
  localparam logic [LEVEL_W-1:0] RST_TRIGGER_LEVEL = 16'd185;
  localparam logic [RUN_W-1:0]   RST_HOLD_FRAMES   = 16'd2205;
  localparam logic [PRE_W-1:0]   RST_PRE_ROLL_LEN  = 7'd64;
  localparam logic [LEVEL_W-1:0] RST_SILENCE_LEVEL = 16'd104;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_RD,
    ST_EMIT
  } ltpg_state_t;

  // Result of the shared magnitude / compare unit
  typedef struct packed {
    logic [SAMPLE_W-1:0] mag;
    logic                loud;
    logic                quiet;
  } ltpg_mag_t;

endpackage

[src/ltpg_mag_unit.sv]
// ----------------------------------------------------------------------------
// ltpg_mag_unit: shared magnitude and level compare unit
// Turns one signed sample into its magnitude and compares it against the
// trigger level and the silence level.
// ----------------------------------------------------------------------------
module ltpg_mag_unit
  import ltpg_pkg::*;
(
  input  logic [SAMPLE_W-1:0] raw,
  input  logic [LEVEL_W-1:0]  trigger_level,
  input  logic [LEVEL_W-1:0]  silence_level,
  output ltpg_mag_t           res
);

  logic [SAMPLE_W-1:0] neg;

  // Two's complement negate; full-scale negative gives 32768 as unsigned
  assign neg = SAMPLE_W'(~raw + SAMPLE_W'(1));

  always_comb begin
    res.mag   = raw[SAMPLE_W-1] ? neg : raw;
    res.loud  = (res.mag >= trigger_level);
    res.quiet = (res.mag < silence_level);
  end

endmodule

[src/level_trigger_pre_roll_gate_unit.sv]
// ----------------------------------------------------------------------------
// level_trigger_pre_roll_gate_unit: level trigger with pre-roll ring
// Tracks peak magnitude, holds samples in a pre-roll ring while armed,
// releases the ring oldest first when the gate fires, then passes through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one signed 16-bit sample per
//   request. Output channel out_valid/out_ready carries sample_out, last,
//   peak and fired; last marks the final result of an input request.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Sequence:
//   A pass-through or ring-filling sample is accepted in ST_IDLE, then goes
//   through the shared magnitude/compare unit in ST_PROC. A sample that fires
//   the gate then releases each of up to 64 ring entries through ST_RD and
//   ST_EMIT, set by the single read port of the ring memory (address in
//   ST_RD, then registered data in ST_EMIT).
// Reset:
//   rst_n (synchronous, active low) closes the gate, clears the run counter,
//   ring fill, write pointer, peak and leading-trim flag, and loads the
//   register defaults. Ring contents are not cleared.
// Stall:
//   A single output register holds the pending result; while it is full and out_ready
//   is low, a step that pushes a result waits; in_ready stays low until the request is done.
// ----------------------------------------------------------------------------
`include "level_trigger_pre_roll_gate_unit_macros.svh"

module level_trigger_pre_roll_gate_unit
  import ltpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_sample,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample_out,
  output logic                  out_last,
  output logic [15:0]           out_peak,
  output logic                  out_fired,
  // Configuration port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic                trig_en_r;
  logic [LEVEL_W-1:0]  trig_level_r;
  logic [RUN_W-1:0]    hold_r;
  logic [PRE_W-1:0]    pre_roll_r;
  logic                trim_r;
  logic [LEVEL_W-1:0]  silence_r;

  // Sequencer and block state
  ltpg_state_t         state_r, state_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                gate_open_r, gate_open_nxt;
  logic [RUN_W-1:0]    loud_run_r, loud_run_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [RING_AW-1:0]  wptr_r, wptr_nxt;
  logic [RING_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]   burst_left_r, burst_left_nxt;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic                lead_done_r, lead_done_nxt;

  // Ring memory
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] ring_rdata_r;
  logic                ring_we;

  // Output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;
  logic [SAMPLE_W-1:0] out_peak_r;
  logic                out_fired_r;

  // Push into the output register
  logic                push;
  logic [SAMPLE_W-1:0] push_sample;
  logic                push_last;
  logic [SAMPLE_W-1:0] push_peak;

  // Shared compare unit
  logic [SAMPLE_W-1:0] mu_raw;
  ltpg_mag_t           mu;

  // Derived terms
  logic                out_free;
  logic [FILL_W-1:0]   len;
  logic [RUN_W-1:0]    need;
  logic [SAMPLE_W-1:0] peak_upd;
  logic [FILL_W-1:0]   fill_a;
  logic [FILL_W-1:0]   fill_c;
  logic [RUN_W-1:0]    run_a;
  logic [RING_AW-1:0]  wptr_a;
  logic                keep;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_en_r    <= 1'b0;
      trig_level_r <= RST_TRIGGER_LEVEL;
      hold_r       <= RST_HOLD_FRAMES;
      pre_roll_r   <= RST_PRE_ROLL_LEN;
      trim_r       <= 1'b1;
      silence_r    <= RST_SILENCE_LEVEL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TRIGGER_ENABLE: trig_en_r    <= cfg_data[0];
        CFG_TRIGGER_LEVEL:  trig_level_r <= cfg_data[LEVEL_W-1:0];
        CFG_HOLD_FRAMES:    hold_r       <= cfg_data[RUN_W-1:0];
        CFG_PRE_ROLL_LEN:   pre_roll_r   <= cfg_data[PRE_W-1:0];
        CFG_TRIM_LEADING:   trim_r       <= cfg_data[0];
        CFG_SILENCE_LEVEL:  silence_r    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand select: ring data during release, else the accepted sample
  assign mu_raw = (state_r == ST_EMIT) ? ring_rdata_r : sample_r;

  ltpg_mag_unit u_mag (
    .raw           (mu_raw),
    .trigger_level (trig_level_r),
    .silence_level (silence_r),
    .res           (mu)
  );

  assign out_free = !out_valid_r || out_ready;
  assign len      = (pre_roll_r > PRE_W'(RING_DEPTH)) ? FILL_W'(RING_DEPTH)
                                                      : FILL_W'(pre_roll_r);
  assign need     = (hold_r == '0) ? RUN_W'(1) : hold_r;
  assign peak_upd = (mu.mag > peak_r) ? mu.mag : peak_r;
  assign keep     = !(trim_r && !lead_done_r && mu.quiet);
  assign in_ready = (state_r == ST_IDLE);

  // Sequencer: next state and block state updates
  always_comb begin
    state_nxt      = state_r;
    gate_open_nxt  = gate_open_r;
    loud_run_nxt   = loud_run_r;
    fill_nxt       = fill_r;
    wptr_nxt       = wptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    burst_left_nxt = burst_left_r;
    peak_nxt       = peak_r;
    lead_done_nxt  = lead_done_r;
    ring_we        = 1'b0;
    push           = 1'b0;
    push_sample    = sample_r;
    push_last      = 1'b1;
    push_peak      = peak_upd;
    fill_a         = fill_r;
    fill_c         = fill_r;
    run_a          = loud_run_r;
    wptr_a         = wptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PROC;
      end

      ST_PROC: begin
        if (trig_en_r && !gate_open_r) begin
          // Armed: store into the ring and count the loud run
          peak_nxt = peak_upd;
          if (len != '0) begin
            ring_we = 1'b1;
            wptr_a  = wptr_r + RING_AW'(1);
            fill_a  = (fill_r < len) ? fill_r + FILL_W'(1) : fill_r;
            if (fill_a > len) fill_a = len;
          end
          wptr_nxt = wptr_a;
          if (mu.loud) begin
            run_a = (loud_run_r == '1) ? loud_run_r : loud_run_r + RUN_W'(1);
          end else begin
            run_a = '0;
          end
          loud_run_nxt = run_a;
          if (run_a >= need) begin
            // Fire: release the ring oldest first
            gate_open_nxt = 1'b1;
            fill_c        = (fill_a > len) ? len : fill_a;
            fill_nxt      = '0;
            if (fill_c != '0) begin
              burst_left_nxt = fill_c;
              rd_ptr_nxt     = wptr_a - fill_c[RING_AW-1:0];
              state_nxt      = ST_RD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            fill_nxt  = fill_a;
            state_nxt = ST_IDLE;
          end
        end else if (out_free) begin
          // Pass-through through the leading-silence gate
          peak_nxt      = peak_upd;
          gate_open_nxt = 1'b1;
          push          = keep;
          if (!mu.quiet) lead_done_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_RD: begin
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          push        = keep;
          push_sample = ring_rdata_r;
          push_last   = (burst_left_r == FILL_W'(1));
          push_peak   = peak_r;
          if (!mu.quiet) lead_done_nxt = 1'b1;
          burst_left_nxt = burst_left_r - FILL_W'(1);
          rd_ptr_nxt     = rd_ptr_r + RING_AW'(1);
          state_nxt      = (burst_left_r == FILL_W'(1)) ? ST_IDLE : ST_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gate_open_r  <= 1'b0;
      loud_run_r   <= '0;
      fill_r       <= '0;
      wptr_r       <= '0;
      rd_ptr_r     <= '0;
      burst_left_r <= '0;
      peak_r       <= '0;
      lead_done_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gate_open_r  <= gate_open_nxt;
      loud_run_r   <= loud_run_nxt;
      fill_r       <= fill_nxt;
      wptr_r       <= wptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      burst_left_r <= burst_left_nxt;
      peak_r       <= peak_nxt;
      lead_done_r  <= lead_done_nxt;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) sample_r <= in_sample;
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wptr_r] <= sample_r;
    if (state_r == ST_RD) ring_rdata_r <= ring_mem[rd_ptr_r];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_sample_r <= push_sample;
      out_last_r   <= push_last;
      out_peak_r   <= push_peak;
      out_fired_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last       = out_last_r;
  assign out_peak       = out_peak_r;
  assign out_fired      = out_fired_r;

  // Checks
  `LTPG_ASSERT_NEXT(a_accept_to_proc, clk, rst_n, in_valid && in_ready, state_r == ST_PROC, "accepted request did not reach processing")
  `LTPG_ASSERT_SAME(a_release_gate_open, clk, rst_n, state_r == ST_RD || state_r == ST_EMIT, gate_open_r, "ring release with gate closed")
  `LTPG_ASSERT_SAME(a_burst_nonzero, clk, rst_n, state_r == ST_RD || state_r == ST_EMIT, burst_left_r != '0 && fill_r == '0, "release count empty or ring fill not cleared")
  `LTPG_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(RING_DEPTH), "ring fill beyond depth")
  `LTPG_ASSERT_NEXT(a_push_valid, clk, rst_n, push, out_valid_r, "pushed result not presented")

endmodule

[tb/tb_level_trigger_pre_roll_gate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_level_trigger_pre_roll_gate_unit: self-checking bench of the level trigger
// Arms the trigger, fills and wraps the pre-roll ring, opens the gate by one
// of three routes picked per seed, then runs pass-through phases with the
// leading trim in several settings. A shadow copy of the gate predicts every
// result; results are checked field by field in order, with random idling.
// ----------------------------------------------------------------------------
module tb_level_trigger_pre_roll_gate_unit;
  import ltpg_pkg::*;

  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic [LEVEL_W-1:0]  peak;
    logic                fired;
  } gate_out_t;

  typedef enum {
    OPEN_BY_FIRE,
    OPEN_BY_FIRE_NO_ROLL,
    OPEN_BY_BYPASS
  } open_path_t;

  // Shadow of the gate: register copies, ring state and the results it owes
  class gate_mirror;
    logic                trig_en;
    logic [LEVEL_W-1:0]  trig_level;
    logic [RUN_W-1:0]    hold_need;
    logic [PRE_W-1:0]    roll_len;
    logic                trim_lead;
    logic [LEVEL_W-1:0]  quiet_level;

    logic                gate_is_open;
    logic [RUN_W-1:0]    run_len;
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    int                  fill;
    int                  wr_ptr;
    logic [LEVEL_W-1:0]  peak_seen;
    logic                lead_seen;

    gate_out_t           burst[$];
    gate_out_t           queued_outputs[$];
    int                  errors;
    int                  samples_seen;
    int                  results_seen;

    function new();
      trig_en      = 1'b0;
      trig_level   = RST_TRIGGER_LEVEL;
      hold_need    = RST_HOLD_FRAMES;
      roll_len     = RST_PRE_ROLL_LEN;
      trim_lead    = 1'b1;
      quiet_level  = RST_SILENCE_LEVEL;
      gate_is_open = 1'b0;
      run_len      = '0;
      fill         = 0;
      wr_ptr       = 0;
      peak_seen    = '0;
      lead_seen    = 1'b0;
      errors       = 0;
      samples_seen = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TRIGGER_ENABLE: trig_en     = val[0];
        CFG_TRIGGER_LEVEL:  trig_level  = val[LEVEL_W-1:0];
        CFG_HOLD_FRAMES:    hold_need   = val[RUN_W-1:0];
        CFG_PRE_ROLL_LEN:   roll_len    = val[PRE_W-1:0];
        CFG_TRIM_LEADING:   trim_lead   = val[0];
        CFG_SILENCE_LEVEL:  quiet_level = val[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // |sample| in 0..32768 always fits 16 unsigned bits
    function logic [SAMPLE_W-1:0] mag_of(logic [SAMPLE_W-1:0] raw);
      return raw[SAMPLE_W-1] ? (~raw + 16'd1) : raw;
    endfunction

    // Leading-silence gate on one outgoing sample
    function void keep(logic [SAMPLE_W-1:0] raw);
      logic      quiet;
      gate_out_t item;
      quiet = mag_of(raw) < quiet_level;
      if (trim_lead && !lead_seen && quiet) return;
      if (!quiet) lead_seen = 1'b1;
      item        = '0;
      item.sample = raw;
      burst = {burst, item};
    endfunction

    // One accepted request: update state, queue the results it causes
    function void take_sample(logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] mag;
      int                  len;
      int                  need;
      int                  start;
      mag = mag_of(raw);
      samples_seen++;
      burst.delete();
      if (mag > peak_seen) peak_seen = mag;
      if (trig_en && !gate_is_open) begin
        len  = (int'(roll_len) > RING_DEPTH) ? RING_DEPTH : int'(roll_len);
        need = (hold_need == '0) ? 1 : int'(hold_need);
        if (len > 0) begin
          ring_mem[wr_ptr] = raw;
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          if (fill < len) fill++;
          if (fill > len) fill = len;
        end
        if (mag >= trig_level) begin
          if (run_len != 16'hFFFF) run_len++;
        end else begin
          run_len = '0;
        end
        // fire: release the ring oldest first
        if (int'(run_len) >= need) begin
          gate_is_open = 1'b1;
          if (fill > len) fill = len;
          start = (wr_ptr + RING_DEPTH - fill) % RING_DEPTH;
          for (int i = 0; i < fill; i++) keep(ring_mem[(start + i) % RING_DEPTH]);
          fill = 0;
        end
      end else begin
        gate_is_open = 1'b1;
        keep(raw);
      end
      foreach (burst[k]) begin
        burst[k].last  = (k == burst.size() - 1);
        burst[k].peak  = peak_seen;
        burst[k].fired = gate_is_open;
        queued_outputs = {queued_outputs, burst[k]};
      end
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // One accepted result against the oldest expectation
    function void match_output(logic [SAMPLE_W-1:0] so, logic lst,
                               logic [LEVEL_W-1:0] pk, logic fd);
      gate_out_t want;
      if (queued_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none, actual sample %0d",
                   $time, $signed(so));
        return;
      end
      want = queued_outputs.pop_front();
      results_seen++;
      if (want.sample !== so) flag("sample_out", $signed(want.sample), $signed(so));
      if (want.last !== lst)  flag("last", want.last, lst);
      if (want.peak !== pk)   flag("peak", want.peak, pk);
      if (want.fired !== fd)  flag("fired", want.fired, fd);
    endfunction

    function void close_out();
      if (queued_outputs.size() != 0) begin
        errors++;
        $display("%0t: results never arrived, expected %0d more, actual 0",
                 $time, queued_outputs.size());
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic signed [15:0]    in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    out_sample_out;
  logic                  out_last;
  logic [15:0]           out_peak;
  logic                  out_fired;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  gate_mirror mirror;
  logic       calm       = 1'b0;
  int         stall_left = 0;
  int         cfg_sets   = 0;

  level_trigger_pre_roll_gate_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_last       (out_last),
    .out_peak       (out_peak),
    .out_fired      (out_fired),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // Sample of a given magnitude with random sign
  function automatic logic signed [15:0] mag_to_sample(input int unsigned m);
    logic [15:0] v;
    v = m[15:0];
    if (m >= 32768) return 16'sh8000;
    if ($urandom_range(0, 1) == 1) return ~v + 16'd1;
    return v;
  endfunction

  // Mix of full-range, near-silence and extreme samples
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return mag_to_sample($urandom_range(0, 400));
      2: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return -16'sd1;
          4: return 16'sd1;
          default: return 16'sh8001;
        endcase
      end
      default: return mag_to_sample($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    mirror.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Full register setting, written back to back while idle
  task automatic apply_cfg(input logic en, input logic [15:0] tl, input logic [15:0] hold,
                           input logic [6:0] pre, input logic trim, input logic [15:0] sil);
    write_reg(CFG_TRIGGER_ENABLE, {15'd0, en});
    write_reg(CFG_TRIGGER_LEVEL, tl);
    write_reg(CFG_HOLD_FRAMES, hold);
    write_reg(CFG_PRE_ROLL_LEN, {9'd0, pre});
    write_reg(CFG_TRIM_LEADING, {15'd0, trim});
    write_reg(CFG_SILENCE_LEVEL, sil);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cfg_sets++;
  endtask

  // Drive a list of sample requests, with random gaps unless calm
  task automatic run_phase(input logic signed [15:0] items[$]);
    int gap;
    foreach (items[i]) begin
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      in_sample <= items[i];
      do @(posedge clk); while (!in_ready);
      mirror.take_sample(items[i]);
    end
    in_valid <= 1'b0;
  endtask

  // Wait for owed results, then for any request still in flight that drops
  task automatic wait_drain();
    int n;
    n = 0;
    while (mirror.queued_outputs.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result monitor and output back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      mirror.match_output(out_sample_out, out_last, out_peak, out_fired);
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic signed [15:0] items[$];
    open_path_t         path;
    logic [15:0]        tl;
    logic [15:0]        hold;
    logic [15:0]        sil;
    logic [6:0]         pre;
    logic               trim;
    int                 need;

    mirror = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Armed with level above full scale: ring fills and nothing comes out
    apply_cfg(1'b1, 16'hFFFF, 16'hFFFF, 7'd127, 1'b1, 16'hFFFF);
    items = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA,
              16'sd184, 16'sd185, -16'sd185, -16'sd186, 16'sd103, 16'sd104, -16'sd104,
              -16'sd105, 16'sh8001};
    run_phase(items);
    @(posedge clk);

    // Random fill, which wraps the ring once the total written passes 64 samples
    items.delete();
    repeat ($urandom_range(40, 80)) items = {items, rand_sample()};
    run_phase(items);
    wait_drain();

    // Shorter pre-roll: only the newest samples stay valid
    apply_cfg(1'b1, 16'hFFFF, 16'hFFFF, 7'($urandom_range(1, 20)), 1'b1, 16'hFFFF);
    items.delete();
    repeat ($urandom_range(3, 10)) items = {items, rand_sample()};
    run_phase(items);
    wait_drain();

    // Gate opens once per run: fire with a ring, fire with no pre-roll, or bypass
    case ($urandom_range(0, 7))
      0:       path = OPEN_BY_BYPASS;
      1:       path = OPEN_BY_FIRE_NO_ROLL;
      default: path = OPEN_BY_FIRE;
    endcase
    tl   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(50, 3000));
    hold = 16'($urandom_range(0, 6));
    need = (hold == 0) ? 1 : int'(hold);
    sil  = 16'($urandom_range(0, 400));
    trim = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       pre = 7'd64;
      1:       pre = 7'd1;
      2:       pre = 7'd127;
      default: pre = 7'($urandom_range(2, 63));
    endcase
    if (path == OPEN_BY_FIRE_NO_ROLL) pre = 7'd0;
    apply_cfg(path != OPEN_BY_BYPASS, tl, hold, pre, trim, sil);

    items.delete();
    if (path != OPEN_BY_BYPASS && tl != 0) begin
      repeat ($urandom_range(0, 4)) items = {items, mag_to_sample($urandom_range(0, tl - 1))};
      // loud run cut short by one quiet sample
      if (need > 1) begin
        repeat (need - 1) items = {items, mag_to_sample($urandom_range(tl, 32768))};
        items = {items, mag_to_sample($urandom_range(0, tl - 1))};
      end
    end
    repeat (need) items = {items, mag_to_sample($urandom_range(tl, 32768))};
    repeat ($urandom_range(5, 15)) items = {items, rand_sample()};
    run_phase(items);
    wait_drain();

    // Pass-through phases; trigger registers no longer matter once open
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin trim = 1'b1; sil = 16'hFFFF; end
        1: begin trim = 1'b1; sil = 16'h8000; end
        2: begin trim = 1'b1; sil = 16'($urandom_range(0, 3000)); end
        3: begin trim = 1'b0; sil = 16'd0; end
        default: begin
          trim = 1'($urandom_range(0, 1));
          sil  = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 32768));
        end
      endcase
      calm = (p == 6);
      apply_cfg(1'($urandom_range(0, 1)), (p == 3) ? 16'd0 : 16'($urandom()),
                (p == 3) ? 16'd0 : 16'($urandom()), 7'($urandom_range(0, 127)), trim, sil);
      items.delete();
      repeat ($urandom_range(35, 45)) items = {items, rand_sample()};
      run_phase(items);
      wait_drain();
    end

    mirror.close_out();
    $display("Summary: %0d samples sent, %0d results checked, gate opened by %s.",
             mirror.samples_seen, mirror.results_seen, path.name());
    $display("Summary: %0d register settings; firing setup pre-roll %0d, hold %0d, level %0d.",
             cfg_sets, pre, hold, tl);
    if (mirror.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ltpg_pkg.sv
src/ltpg_mag_unit.sv
src/level_trigger_pre_roll_gate_unit.sv
tb/tb_level_trigger_pre_roll_gate_unit.sv
